// ===== rtl/core/tdla_pkg.sv =====
// ----------------------------------------------------------------------------
// tdla_pkg
// Shared types, codes and constant tables of the time-decayed load average.
// ----------------------------------------------------------------------------
package tdla_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_MERGE  = 2'd2;
	localparam logic [1:0] CMD_SHIFT  = 2'd3;

	localparam logic [1:0] REG_FACTOR    = 2'd0;
	localparam logic [1:0] REG_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam logic [21:0] E_CAP = 22'(40 << 16);
	localparam logic [63:0] WMAX  = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMAX  = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_LOG_MUL, S_LOG_ACC, S_LOG_END,
		S_DIV1_GO, S_DIV1_WAIT, S_LQ_MUL, S_LR_MUL, S_DIV2_GO, S_DIV2_WAIT,
		S_E_CALC, S_EXP_MUL, S_EXP_ACC, S_COEF,
		S_MUL_WH, S_MUL_WL, S_MUL_GH, S_MUL_GL, S_GDEC, S_APPLY,
		S_AVG_GO, S_AVG_WAIT, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_DISPATCH, OP_LOG_MUL, OP_LOG_ACC, OP_LOG_END,
		OP_DIV1_GO, OP_LQ_MUL, OP_LR_MUL, OP_DIV2_GO, OP_E_CALC,
		OP_EXP_MUL, OP_EXP_ACC, OP_COEF,
		OP_MUL_WH, OP_MUL_WL, OP_MUL_GH, OP_MUL_GL, OP_GDEC, OP_APPLY,
		OP_AVG_GO, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] iter;
	} dp_cmd_t;

	typedef struct packed {
		logic decay;
		logic c_gt;
		logic div_busy;
	} dp_sts_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] rv;
		integer i;
		res = '0;
		bv = 64'h4000_0000_0000_0000;
		rv = v;
		for (i = 0; i < 32; i++) begin
			if (bv > rv) bv = bv >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (bv != 0) begin
				if (rv >= res + bv) begin
					rv = rv - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		end
		return res;
	endfunction

	// 2^-(2^-(k+1)) in Q1.30, by the chain of square roots
	function automatic logic [30:0] exp_root(input int k);
		logic [63:0] r;
		integer j;
		r = isqrt64(64'd1 << 59);
		for (j = 0; j < 16; j++) begin
			if (j < k) r = isqrt64(r << 30);
		end
		return r[30:0];
	endfunction

endpackage

// ===== rtl/core/tdla_div.sv =====
// ----------------------------------------------------------------------------
// tdla_div
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdla_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quot,
	output logic [63:0] rem,
	output logic        busy
);
	logic [63:0] quot_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] shifted;
	logic        ge;
	logic [64:0] diff;

	assign shifted = {rem_q, quot_q[63]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[62:0], ge};
			rem_q  <= ge ? diff[63:0] : shifted[63:0];
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign busy = busy_q;

endmodule

// ===== rtl/core/tdla_dp.sv =====
// ----------------------------------------------------------------------------
// tdla_dp
// Datapath: statistics registers, shared multiplier, divider, log/exp steps.
// ----------------------------------------------------------------------------
module tdla_dp #(
	parameter int unsigned FRAC_BITS = tdla_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tdla_pkg::dp_cmd_t dcmd,
	output tdla_pkg::dp_sts_t sts,
	input  logic [15:0]       decay_factor,
	input  logic [31:0]       decay_interval,
	input  logic [15:0]       restart_threshold,
	input  logic [1:0]        cmd,
	input  logic [31:0]       value,
	input  logic [62:0]       timestamp,
	input  logic [62:0]       time_shift,
	input  logic [63:0]       other_weighted_sum,
	input  logic [47:0]       other_weight_sum,
	input  logic [31:0]       other_count,
	output logic              updated,
	output logic [31:0]       average,
	output logic [31:0]       report_count
);
	import tdla_pkg::*;

	localparam logic [47:0] ONE_W = 48'(1) << FRAC_BITS;
	localparam logic [30:0] ROOTS [16] = '{
		exp_root(0),  exp_root(1),  exp_root(2),  exp_root(3),
		exp_root(4),  exp_root(5),  exp_root(6),  exp_root(7),
		exp_root(8),  exp_root(9),  exp_root(10), exp_root(11),
		exp_root(12), exp_root(13), exp_root(14), exp_root(15)
	};

	// item
	logic [1:0]  cmd_q;
	logic [31:0] val_q;
	logic [62:0] ts_q;
	logic [62:0] shift_q;
	logic [63:0] ows_q;
	logic [47:0] ogs_q;
	logic [31:0] ocnt_q;
	// statistics
	logic [31:0] last_value_q;
	logic [63:0] last_time_q;
	logic [31:0] reports_q;
	logic [63:0] wsum_q;
	logic [47:0] gsum_q;
	// work
	logic        upd_q;
	logic        later_q;
	logic [63:0] mag_q;
	logic [30:0] x_q;
	logic [15:0] frac_q;
	logic [3:0]  p_q;
	logic [20:0] l_q;
	logic        qbig_q;
	logic [40:0] t1_q;
	logic [15:0] g_q;
	logic [5:0]  n_q;
	logic [31:0] c_q;
	logic        c_gt_q;
	logic [63:0] prod_q;
	logic [63:0] ph_q;
	logic [63:0] wdec_q;
	logic [47:0] gdec_q;
	logic [31:0] avg_q;
	logic [31:0] cnt_q;
	logic        upd_out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        div_go;
	logic [63:0] div_dvd;
	logic [63:0] div_dvs;
	logic [63:0] quot;
	logic [63:0] rem;
	logic        div_busy;

	logic        later;
	logic [31:0] d_eff;
	logic [63:0] shift_ext;
	logic [3:0]  p_init;
	logic [31:0] sqr;
	logic [41:0] esum;
	logic [21:0] e_f;
	logic [22:0] e_up;
	logic [16:0] y_hi;
	logic [46:0] v_bwd;
	logic [31:0] c_next;
	logic [63:0] add_s;
	logic [47:0] add_w;
	logic [31:0] add_c;
	logic [64:0] ws_add;
	logic [48:0] gs_add;
	logic [32:0] rc_add;
	logic [47:0] gs_div;
	logic [31:0] avg_next;

	function automatic logic [63:0] mulc(input logic [63:0] ph, input logic [63:0] pl,
			input logic [63:0] lim);
		logic [64:0] s;
		s = {1'b0, ph[47:0], 16'b0} + {17'b0, pl[63:16]};
		if (ph[63:48] != '0) return lim;
		return (s > {1'b0, lim}) ? lim : s[63:0];
	endfunction

	tdla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quot     (quot),
		.rem      (rem),
		.busy     (div_busy)
	);

	assign later     = $signed({1'b0, ts_q}) > $signed(last_time_q);
	assign d_eff     = (decay_interval == '0) ? 32'd1 : decay_interval;
	assign shift_ext = {shift_q[62], shift_q};
	assign sqr       = prod_q[61:30];
	assign gs_div    = (gsum_q == '0) ? 48'd1 : gsum_q;

	always_comb begin
		p_init = '0;
		for (int i = 1; i < 16; i++) begin
			if (decay_factor[i]) p_init = 4'(i);
		end
	end

	always_comb begin
		esum = 42'(t1_q) + quot[41:0];
		if (qbig_q || quot[63:42] != '0 || esum > 42'(E_CAP)) e_f = E_CAP;
		else e_f = esum[21:0];
		e_up = 23'(e_f) + 23'h00FFFF;
	end

	always_comb begin
		y_hi  = x_q[30:14];
		v_bwd = (47'(x_q) << n_q) >> 14;
		if (later_q) begin
			c_next = (n_q >= 6'd17) ? 32'd0 : (32'(y_hi) >> n_q);
		end else if (n_q >= 6'd17 || v_bwd[46:32] != '0) begin
			c_next = 32'hFFFF_FFFF;
		end else begin
			c_next = v_bwd[31:0];
		end
	end

	always_comb begin
		add_s = (cmd_q == CMD_REPORT) ? (64'(val_q) << FRAC_BITS) : ows_q;
		add_w = (cmd_q == CMD_REPORT) ? ONE_W : ogs_q;
		add_c = (cmd_q == CMD_REPORT) ? 32'd1 : ocnt_q;
		ws_add = {1'b0, wdec_q} + {1'b0, add_s};
		gs_add = {1'b0, gdec_q} + {1'b0, add_w};
		rc_add = {1'b0, reports_q} + {1'b0, add_c};
	end

	always_comb begin
		if (decay_factor == '0 || reports_q == 32'd1) avg_next = last_value_q;
		else if (wsum_q == '0) avg_next = '0;
		else if (quot[63:32] != '0) avg_next = 32'hFFFF_FFFF;
		else avg_next = quot[31:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (dcmd.op)
			OP_LOG_MUL: begin
				mul_a = 32'(x_q);
				mul_b = 32'(x_q);
			end
			OP_LQ_MUL: begin
				mul_a = 32'(l_q);
				mul_b = 32'(quot[19:0]);
			end
			OP_LR_MUL: begin
				mul_a = 32'(l_q);
				mul_b = rem[31:0];
			end
			OP_EXP_MUL: begin
				mul_a = 32'(x_q);
				mul_b = 32'(ROOTS[dcmd.iter]);
			end
			OP_MUL_WH: begin
				mul_a = wsum_q[63:32];
				mul_b = c_q;
			end
			OP_MUL_WL: begin
				mul_a = wsum_q[31:0];
				mul_b = c_q;
			end
			OP_MUL_GH: begin
				mul_a = 32'(gsum_q[47:32]);
				mul_b = c_q;
			end
			OP_MUL_GL: begin
				mul_a = gsum_q[31:0];
				mul_b = c_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		div_go  = 1'b0;
		div_dvd = '0;
		div_dvs = 64'(d_eff);
		case (dcmd.op)
			OP_DIV1_GO: begin
				div_go  = 1'b1;
				div_dvd = mag_q;
			end
			OP_DIV2_GO: begin
				div_go  = 1'b1;
				div_dvd = prod_q;
			end
			OP_AVG_GO: begin
				div_go  = 1'b1;
				div_dvd = wsum_q;
				div_dvs = 64'(gs_div);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_value_q <= '0;
			last_time_q  <= '0;
			reports_q    <= 32'd1;
			wsum_q       <= '0;
			gsum_q       <= ONE_W;
		end else begin
			case (dcmd.op)
				OP_DISPATCH: begin
					case (cmd_q)
						CMD_START: begin
							last_value_q <= val_q;
							last_time_q  <= 64'(ts_q);
							reports_q    <= 32'd1;
							wsum_q       <= 64'(val_q) << FRAC_BITS;
							gsum_q       <= ONE_W;
						end
						CMD_SHIFT: last_time_q <= last_time_q + shift_ext;
						default: begin
							if (decay_factor == '0) begin
								if (later) begin
									if (reports_q > 32'd1 || last_value_q != val_q) begin
										last_value_q <= val_q;
										last_time_q  <= 64'(ts_q);
										wsum_q       <= 64'(val_q) << FRAC_BITS;
										if (reports_q > 32'd1) begin
											reports_q <= 32'd1;
											gsum_q    <= ONE_W;
										end
									end
								end else if (reports_q > 32'd1) begin
									reports_q <= 32'd1;
									wsum_q    <= 64'(last_value_q) << FRAC_BITS;
									gsum_q    <= ONE_W;
								end
							end
						end
					endcase
				end
				OP_APPLY: begin
					if (c_gt_q) begin
						wsum_q <= ws_add[64] ? SMAX : ws_add[63:0];
						gsum_q <= (gs_add > 49'(WMAX)) ? WMAX[47:0] : gs_add[47:0];
					end else begin
						wsum_q <= add_s;
						gsum_q <= add_w;
					end
					if (later_q) begin
						last_value_q <= val_q;
						last_time_q  <= 64'(ts_q);
					end
					reports_q <= rc_add[32] ? 32'hFFFF_FFFF : rc_add[31:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_LOAD: begin
				cmd_q   <= cmd;
				val_q   <= value;
				ts_q    <= timestamp;
				shift_q <= time_shift;
				ows_q   <= other_weighted_sum;
				ogs_q   <= other_weight_sum;
				ocnt_q  <= other_count;
			end
			OP_DISPATCH: begin
				upd_q   <= 1'b0;
				later_q <= later;
				mag_q   <= later ? (64'(ts_q) - last_time_q) : (last_time_q - 64'(ts_q));
				p_q     <= p_init;
				x_q     <= 31'(32'(decay_factor) << (5'd30 - 5'(p_init)));
				frac_q  <= '0;
				if (cmd_q == CMD_START) begin
					upd_q <= 1'b1;
				end else if (cmd_q != CMD_SHIFT && decay_factor == '0) begin
					upd_q <= (later && (reports_q > 32'd1 || last_value_q != val_q))
						|| (!later && reports_q > 32'd1);
				end
			end
			OP_LOG_ACC: begin
				if (sqr[31]) begin
					x_q <= sqr[31:1];
					frac_q[4'd15 - dcmd.iter] <= 1'b1;
				end else begin
					x_q <= sqr[30:0];
				end
			end
			OP_LOG_END: l_q <= (21'(5'd16 - 5'(p_q)) << 16) - 21'(frac_q);
			OP_LQ_MUL: qbig_q <= quot[63:20] != '0;
			OP_LR_MUL: t1_q <= prod_q[40:0];
			OP_E_CALC: begin
				x_q <= 31'(1) << 30;
				if (later_q) begin
					n_q <= e_f[21:16];
					g_q <= e_f[15:0];
				end else begin
					n_q <= e_up[21:16];
					g_q <= 16'(~e_f[15:0] + 16'd1);
				end
			end
			OP_EXP_ACC: begin
				if (g_q[4'd15 - dcmd.iter]) x_q <= prod_q[60:30];
			end
			OP_COEF: begin
				c_q    <= c_next;
				c_gt_q <= c_next > 32'(restart_threshold);
			end
			OP_MUL_WL: ph_q <= prod_q;
			OP_MUL_GH: wdec_q <= mulc(ph_q, prod_q, SMAX);
			OP_MUL_GL: ph_q <= prod_q;
			OP_GDEC: gdec_q <= 48'(mulc(ph_q, prod_q, WMAX));
			OP_APPLY: upd_q <= 1'b1;
			OP_OUT: begin
				avg_q     <= avg_next;
				cnt_q     <= reports_q;
				upd_out_q <= upd_q;
			end
			default: ;
		endcase
	end

	assign sts.decay    = (cmd_q == CMD_REPORT || cmd_q == CMD_MERGE) && decay_factor != '0;
	assign sts.c_gt     = c_next > 32'(restart_threshold);
	assign sts.div_busy = div_busy;

	assign updated      = upd_out_q;
	assign average      = avg_q;
	assign report_count = cnt_q;

endmodule

// ===== rtl/core/tdla_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdla_ctrl
// Sequencer: steps the datapath through one item and owns the handshakes.
// ----------------------------------------------------------------------------
module tdla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output tdla_pkg::dp_cmd_t dcmd,
	input  tdla_pkg::dp_sts_t sts
);
	import tdla_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] iter_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (s_tvalid) state_d = S_DISPATCH;
			S_DISPATCH:  state_d = sts.decay ? S_LOG_MUL : S_AVG_GO;
			S_LOG_MUL:   state_d = S_LOG_ACC;
			S_LOG_ACC:   state_d = (iter_q == 4'd15) ? S_LOG_END : S_LOG_MUL;
			S_LOG_END:   state_d = S_DIV1_GO;
			S_DIV1_GO:   state_d = S_DIV1_WAIT;
			S_DIV1_WAIT: if (!sts.div_busy) state_d = S_LQ_MUL;
			S_LQ_MUL:    state_d = S_LR_MUL;
			S_LR_MUL:    state_d = S_DIV2_GO;
			S_DIV2_GO:   state_d = S_DIV2_WAIT;
			S_DIV2_WAIT: if (!sts.div_busy) state_d = S_E_CALC;
			S_E_CALC:    state_d = S_EXP_MUL;
			S_EXP_MUL:   state_d = S_EXP_ACC;
			S_EXP_ACC:   state_d = (iter_q == 4'd15) ? S_COEF : S_EXP_MUL;
			S_COEF:      state_d = sts.c_gt ? S_MUL_WH : S_APPLY;
			S_MUL_WH:    state_d = S_MUL_WL;
			S_MUL_WL:    state_d = S_MUL_GH;
			S_MUL_GH:    state_d = S_MUL_GL;
			S_MUL_GL:    state_d = S_GDEC;
			S_GDEC:      state_d = S_APPLY;
			S_APPLY:     state_d = S_AVG_GO;
			S_AVG_GO:    state_d = S_AVG_WAIT;
			S_AVG_WAIT:  if (!sts.div_busy) state_d = S_OUT;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		dcmd.op   = OP_NONE;
		dcmd.iter = iter_q;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) dcmd.op = OP_LOAD;
			end
			S_DISPATCH: dcmd.op = OP_DISPATCH;
			S_LOG_MUL:  dcmd.op = OP_LOG_MUL;
			S_LOG_ACC:  dcmd.op = OP_LOG_ACC;
			S_LOG_END:  dcmd.op = OP_LOG_END;
			S_DIV1_GO:  dcmd.op = OP_DIV1_GO;
			S_LQ_MUL:   dcmd.op = OP_LQ_MUL;
			S_LR_MUL:   dcmd.op = OP_LR_MUL;
			S_DIV2_GO:  dcmd.op = OP_DIV2_GO;
			S_E_CALC:   dcmd.op = OP_E_CALC;
			S_EXP_MUL:  dcmd.op = OP_EXP_MUL;
			S_EXP_ACC:  dcmd.op = OP_EXP_ACC;
			S_COEF:     dcmd.op = OP_COEF;
			S_MUL_WH:   dcmd.op = OP_MUL_WH;
			S_MUL_WL:   dcmd.op = OP_MUL_WL;
			S_MUL_GH:   dcmd.op = OP_MUL_GH;
			S_MUL_GL:   dcmd.op = OP_MUL_GL;
			S_GDEC:     dcmd.op = OP_GDEC;
			S_APPLY:    dcmd.op = OP_APPLY;
			S_AVG_GO:   dcmd.op = OP_AVG_GO;
			S_OUT:      if (out_free) dcmd.op = OP_OUT;
			default:    dcmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iter_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOG_ACC || state_q == S_EXP_ACC) iter_q <= iter_q + 4'd1;
			if (state_q == S_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_DISPATCH)
		else $error("accepted item did not reach dispatch");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output step");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !sts.div_busy)
		else $error("divider busy while idle");

	a_iter_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOG_END || state_q == S_COEF |-> iter_q == 4'd0)
		else $error("iteration count out of step");

endmodule

// ===== rtl/core/time_decayed_load_average_core.sv =====
// ----------------------------------------------------------------------------
// time_decayed_load_average_core
// Time-decayed weighted average of load reports with APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream (s_tuser = command, s_tdata = operands) and
//   each item gives exactly one result on the m_ stream (m_tuser = updated
//   flag, m_tdata = average and report count).
//   One item is worked at a time. A report or merge with a nonzero decay
//   factor goes from transfer to result through 16 log squarings and 16
//   exp steps on the shared 32x32 multiplier and three passes of the
//   serial divider (interval split, exponent fraction, average).
//   Start, time shift and newest-value items skip these steps and pass
//   only through the average division.
//   The result waits in an output register; the next item is taken while it
//   waits, and its result is held back until the receiver takes the first.
//   Reset clears the statistics to an empty average and the registers to
//   their defaults; write the registers over APB only while idle.
// ----------------------------------------------------------------------------
module time_decayed_load_average_core #(
	parameter int unsigned FRAC_BITS = tdla_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// value, timestamp, time_shift, other_weighted_sum, other_weight_sum, other_count
	input  logic [303:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// average, report_count
	output logic [63:0]  m_tdata,
	// updated
	output logic         m_tuser
);
	import tdla_pkg::*;

	logic [15:0] decay_factor_q;
	logic [31:0] decay_interval_q;
	logic [15:0] restart_threshold_q;
	dp_cmd_t     dcmd;
	dp_sts_t     sts;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_factor_q      <= '0;
			decay_interval_q    <= 32'd1;
			restart_threshold_q <= 16'd1;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FACTOR:    decay_factor_q      <= pwdata[15:0];
				REG_INTERVAL:  decay_interval_q    <= pwdata;
				REG_THRESHOLD: restart_threshold_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FACTOR:    prdata = 32'(decay_factor_q);
			REG_INTERVAL:  prdata = decay_interval_q;
			REG_THRESHOLD: prdata = 32'(restart_threshold_q);
			default:       prdata = '0;
		endcase
	end

	tdla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dcmd     (dcmd),
		.sts      (sts)
	);

	tdla_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.dcmd               (dcmd),
		.sts                (sts),
		.decay_factor       (decay_factor_q),
		.decay_interval     (decay_interval_q),
		.restart_threshold  (restart_threshold_q),
		.cmd                (s_tuser),
		.value              (s_tdata[31:0]),
		.timestamp          (s_tdata[94:32]),
		.time_shift         (s_tdata[157:95]),
		.other_weighted_sum (s_tdata[221:158]),
		.other_weight_sum   (s_tdata[269:222]),
		.other_count        (s_tdata[301:270]),
		.updated            (m_tuser),
		.average            (m_tdata[31:0]),
		.report_count       (m_tdata[63:32])
	);

endmodule
